@@ rtl/dsmc_pkg.sv @@
// Package for the door stepper motion controller: payload structs,
// register indexes, fault and error codes. No dependencies.
`timescale 1ns / 1ps
package dsmc_pkg;

	localparam int unsigned CFG_IDX_BITS = 3;
	localparam int unsigned CFG_DATA_BITS = 16;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_SPEED_MIN     = 3'd0,
		REG_SPEED_MAX     = 3'd1,
		REG_DEFAULT_SPEED = 3'd2,
		REG_RAMP_UP       = 3'd3,
		REG_RAMP_DOWN     = 3'd4,
		REG_TRAVEL_TO     = 3'd5,
		REG_INIT_TO       = 3'd6,
		REG_STANDING_TIME = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_CLOSE = 2'd1,
		ERR_OPEN  = 2'd2,
		ERR_INIT  = 2'd3
	} err_code_t;

	localparam int unsigned F_CLOSE_BIT = 0;
	localparam int unsigned F_OPEN_BIT  = 1;
	localparam int unsigned F_INIT_BIT  = 2;

	localparam logic [7:0] SPEED_RESET = 8'd100;
	localparam logic [7:0] DIV_RESET   = 8'd156;

	typedef struct packed {
		logic ms_tick;
		logic closed_limit;
		logic open_limit;
		logic close_button;
		logic open_button;
		logic obstacle;
		logic open_request;
		logic passcode_open;
	} tick_in_t;

	typedef struct packed {
		logic        step_pin;
		logic        dir_pin;
		logic        hold_pin;
		logic        motor_running;
		logic [1:0]  error_code;
		logic [19:0] learned_span;
		logic        homed;
	} tick_out_t;

	typedef struct packed {
		logic [7:0]  speed_min;
		logic [7:0]  speed_max;
		logic [7:0]  default_speed;
		logic [7:0]  ramp_up_interval;
		logic [7:0]  ramp_down_interval;
		logic [15:0] travel_timeout;
		logic [15:0] init_timeout;
		logic [15:0] standing_time;
	} cfg_t;

endpackage

@@ rtl/door_stepper_motion_controller.sv @@
// Channel   | valid       | ready       | payload
// in        | in_valid    | in_ready    | in_data  (tick_in_t)
// out       | out_valid   | out_ready   | out_data (tick_out_t)
// cfg       | cfg_valid   | cfg_ready   | cfg_index, cfg_data
//
// One tick per clock: the controller state updates at the cycle the tick is
// accepted and the result lands in the output register the same edge. A
// stalled output register holds in_ready low only while it is full and not
// being taken. Reset returns control state and registers to their defaults
// (speed code 100, divider limit 156).
// Top level of the door controller; depends on dsmc_pkg and dsmc_cfg_regs.
`timescale 1ns / 1ps
module door_stepper_motion_controller #(
	parameter int unsigned STEP_COUNT_BITS = 20,
	parameter int unsigned TIMER_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  dsmc_pkg::tick_in_t                 in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output dsmc_pkg::tick_out_t                out_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [dsmc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [dsmc_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import dsmc_pkg::*;

	localparam int unsigned CB = STEP_COUNT_BITS;
	localparam int unsigned TB = TIMER_BITS;

	cfg_t cfg;
	dsmc_cfg_regs u_cfg (
		.clk(clk), .arst_n(arst_n), .cfg_valid(cfg_valid),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .cfg(cfg)
	);
	assign cfg_ready = 1'b1;

	// state
	logic homed_q, learned_q, mopen_q, mclose_q, run_q, motor_q, cnt_en_q;
	logic span_rd_q, prof_q, pass_q, wopen_q, wclose_q, stand_q, phase_q;
	logic [2:0] fault_q;
	logic [CB-1:0] step_q, open_span_q, reopen_q, cruise_q, accel_q;
	logic [7:0] speed_q, div_lim_q, div_cnt_q, ramp_q;
	logic [TB-1:0] trav_q, home_q, standt_q;
	logic step_lvl_q, dir_q;

	// next state
	logic homed_d, learned_d, mopen_d, mclose_d, run_d, motor_d, cnt_en_d;
	logic span_rd_d, prof_d, pass_d, wopen_d, wclose_d, stand_d, phase_d;
	logic [2:0] fault_d;
	logic [CB-1:0] step_d, open_span_d, reopen_d, cruise_d, accel_d, base, rest;
	logic [CB:0] full;
	logic [7:0] speed_d, div_lim_d, div_cnt_d, ramp_d;
	logic [TB-1:0] trav_d, home_d, standt_d;
	logic step_lvl_d, dir_d;
	logic cl, ol, b1, b2, fir;

	logic accept;
	assign in_ready = !out_valid || out_ready;
	assign accept = in_valid && in_ready;

	function automatic logic [7:0] div_of(input logic [7:0] v, input logic [7:0] mx,
			input logic [7:0] mn);
		logic [7:0] t;
		t = v;
		if (t > mx) t = mx;
		if (t < mn) t = mn;
		return 8'(9'd256 - {1'b0, t});
	endfunction

	always_comb begin
		homed_d = homed_q; learned_d = learned_q; mopen_d = mopen_q; mclose_d = mclose_q;
		run_d = run_q; motor_d = motor_q; cnt_en_d = cnt_en_q; span_rd_d = span_rd_q;
		prof_d = prof_q; pass_d = pass_q; wopen_d = wopen_q; wclose_d = wclose_q;
		stand_d = stand_q; phase_d = phase_q; fault_d = fault_q; step_d = step_q;
		open_span_d = open_span_q; reopen_d = reopen_q; cruise_d = cruise_q;
		accel_d = accel_q; speed_d = speed_q; div_lim_d = div_lim_q;
		div_cnt_d = div_cnt_q; ramp_d = ramp_q; trav_d = trav_q; home_d = home_q;
		standt_d = standt_q; step_lvl_d = step_lvl_q; dir_d = dir_q;
		base = '0; rest = '0; full = '0;
		cl = in_data.closed_limit; ol = in_data.open_limit;
		b1 = in_data.close_button; b2 = in_data.open_button; fir = in_data.obstacle;

		if (in_data.passcode_open) pass_d = 1'b1;

		if (in_data.ms_tick) begin
			trav_d = (trav_q != '0) ? trav_q - 1'b1 : '0;
			home_d = (home_q != '0) ? home_q - 1'b1 : '0;
			standt_d = (standt_q != '0) ? standt_q - 1'b1 : '0;
			ramp_d = (ramp_q != '0) ? ramp_q - 8'd1 : '0;

			// homing
			if (!homed_d) begin
				if (!cl && !motor_d) begin
					mclose_d = 1'b1; mopen_d = 1'b0;
					div_lim_d = div_of(cfg.default_speed, cfg.speed_max, cfg.speed_min);
					dir_d = 1'b0;
					cnt_en_d = 1'b1; motor_d = 1'b1;
					home_d = TB'(cfg.init_timeout);
				end else if (cl) begin
					cnt_en_d = 1'b0; motor_d = 1'b0; step_d = '0;
					mopen_d = 1'b0; mclose_d = 1'b0; homed_d = 1'b1;
				end
				if (motor_d && mclose_d && !cl && home_d == '0) begin
					cnt_en_d = 1'b0; motor_d = 1'b0; step_d = '0; homed_d = 1'b1;
					mclose_d = 1'b0; fault_d[F_INIT_BIT] = 1'b1;
				end
			end

			if (homed_d) begin
				if (open_span_d != '0 && (b2 || in_data.open_request || pass_d) && !run_d) begin
					run_d = 1'b1; mopen_d = 1'b1; step_d = '0; prof_d = 1'b0; pass_d = 1'b0;
				end
				// learning runs
				if (open_span_d == '0 || !learned_d) begin
					if (cl && !span_rd_d) begin
						mclose_d = 1'b0; mopen_d = 1'b1;
						if (!wopen_d) begin
							trav_d = TB'(cfg.travel_timeout); wopen_d = 1'b1;
						end else if (trav_d == '0) begin
							fault_d[F_OPEN_BIT] = 1'b1; wopen_d = 1'b0;
							cnt_en_d = 1'b0; motor_d = 1'b0; run_d = 1'b0;
						end
						div_lim_d = div_of(cfg.default_speed, cfg.speed_max, cfg.speed_min);
						dir_d = 1'b1; cnt_en_d = 1'b1; motor_d = 1'b1;
					end else if (ol && mopen_d && !span_rd_d) begin
						open_span_d = step_d;
						span_rd_d = 1'b1; prof_d = 1'b0; step_d = '0;
						mclose_d = 1'b1; mopen_d = 1'b0;
						div_lim_d = div_of(cfg.default_speed, cfg.speed_max, cfg.speed_min);
						dir_d = 1'b0; cnt_en_d = 1'b1; motor_d = 1'b1;
					end else if (cl && mclose_d && span_rd_d) begin
						cnt_en_d = 1'b0; motor_d = 1'b0;
						mopen_d = 1'b0; mclose_d = 1'b0; learned_d = 1'b1;
					end
				end

				// run control
				if (run_d) begin
					if (mopen_d) begin
						if (!ol) begin
							if (!prof_d && open_span_d != '0) begin
								base = open_span_d;
								cruise_d = base >> 1;
								rest = base - cruise_d;
								accel_d = rest >> 1;
								prof_d = 1'b1;
							end
							cnt_en_d = 1'b1; motor_d = 1'b1; dir_d = 1'b1;
							full = {1'b0, accel_d} + {1'b0, cruise_d};
							if (step_d < accel_d) begin
								if (ramp_d == '0) begin
									speed_d = speed_d + 8'd1; ramp_d = cfg.ramp_up_interval;
								end
								if (speed_d >= cfg.speed_max) speed_d = cfg.speed_max;
							end else if (step_d > accel_d && {1'b0, step_d} < full) begin
								speed_d = cfg.speed_max;
							end else if ({1'b0, step_d} > full) begin
								if (ramp_d == '0) begin
									speed_d = speed_d - 8'd1; ramp_d = cfg.ramp_down_interval;
								end
								if (speed_d <= cfg.speed_min) speed_d = cfg.speed_min;
							end
							div_lim_d = div_of(speed_d, cfg.speed_max, cfg.speed_min);
							if (!wopen_d) begin
								trav_d = TB'(cfg.travel_timeout); wopen_d = 1'b1;
							end else if (trav_d == '0) begin
								fault_d[F_OPEN_BIT] = 1'b1; wopen_d = 1'b0;
								cnt_en_d = 1'b0; motor_d = 1'b0; run_d = 1'b0;
							end
							span_rd_d = 1'b0;
						end else begin
							cnt_en_d = 1'b0; motor_d = 1'b0;
							if (!span_rd_d) begin
								span_rd_d = 1'b1; prof_d = 1'b0; step_d = '0;
							end
							if (!stand_d) begin
								standt_d = TB'(cfg.standing_time); stand_d = 1'b1;
							end else if (standt_d == '0 || b2) begin
								stand_d = 1'b0; mclose_d = 1'b1; mopen_d = 1'b0;
								prof_d = 1'b0; speed_d = cfg.speed_min; step_d = '0;
							end
							wopen_d = 1'b0; wclose_d = 1'b0; trav_d = '0; home_d = '0;
						end
					end else if (mclose_d) begin
						if (fir || b1) begin
							mopen_d = 1'b1; mclose_d = 1'b0;
							cnt_en_d = 1'b0; motor_d = 1'b0;
							if (!span_rd_d) begin
								if (!ol) reopen_d = step_d;
								span_rd_d = 1'b1; prof_d = 1'b0; step_d = '0;
							end
							if (!prof_d && open_span_d != '0) begin
								base = reopen_d;
								cruise_d = base >> 1;
								rest = base - cruise_d;
								accel_d = rest >> 1;
								prof_d = 1'b1;
							end
							speed_d = cfg.speed_min;
							wopen_d = 1'b0; wclose_d = 1'b0; trav_d = '0; home_d = '0;
						end else if (!cl) begin
							if (!prof_d && open_span_d != '0) begin
								base = open_span_d;
								cruise_d = base >> 1;
								rest = base - cruise_d;
								accel_d = rest >> 1;
								prof_d = 1'b1;
							end
							cnt_en_d = 1'b1; motor_d = 1'b1; dir_d = 1'b0;
							full = {1'b0, accel_d} + {1'b0, cruise_d};
							if (step_d < accel_d) begin
								if (ramp_d == '0) begin
									speed_d = speed_d + 8'd1; ramp_d = cfg.ramp_up_interval;
								end
								if (speed_d >= cfg.speed_max) speed_d = cfg.speed_max;
							end else if (step_d > accel_d && {1'b0, step_d} < full) begin
								speed_d = cfg.speed_max;
							end else if ({1'b0, step_d} > full) begin
								if (ramp_d == '0) begin
									speed_d = speed_d - 8'd1; ramp_d = cfg.ramp_down_interval;
								end
								if (speed_d <= cfg.speed_min) speed_d = cfg.speed_min;
							end
							div_lim_d = div_of(speed_d, cfg.speed_max, cfg.speed_min);
							// close timeout runs on the homing timer
							if (!wclose_d) begin
								home_d = TB'(cfg.travel_timeout); wclose_d = 1'b1;
							end else if (home_d == '0) begin
								fault_d[F_CLOSE_BIT] = 1'b1; wclose_d = 1'b0;
								cnt_en_d = 1'b0; motor_d = 1'b0; run_d = 1'b0;
							end
							span_rd_d = 1'b0;
						end else begin
							cnt_en_d = 1'b0; motor_d = 1'b0;
							mclose_d = 1'b0; run_d = 1'b0;
							wopen_d = 1'b0; wclose_d = 1'b0; trav_d = '0; home_d = '0;
						end
					end
				end
			end
		end

		// step pulse generator
		if (motor_d) begin
			div_cnt_d = div_cnt_q + 8'd1;
			if (div_cnt_d > div_lim_d) begin
				div_cnt_d = '0;
				if (phase_q) begin
					step_lvl_d = 1'b1; phase_d = 1'b0;
					if (cnt_en_d) step_d = step_d + 1'b1;
				end else begin
					step_lvl_d = 1'b0; phase_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			homed_q <= 1'b0; learned_q <= 1'b0; mopen_q <= 1'b0; mclose_q <= 1'b0;
			run_q <= 1'b0; motor_q <= 1'b0; cnt_en_q <= 1'b0; span_rd_q <= 1'b0;
			prof_q <= 1'b0; pass_q <= 1'b0; wopen_q <= 1'b0; wclose_q <= 1'b0;
			stand_q <= 1'b0; phase_q <= 1'b0; fault_q <= '0; step_q <= '0;
			open_span_q <= '0; reopen_q <= '0; cruise_q <= '0; accel_q <= '0;
			speed_q <= SPEED_RESET; div_lim_q <= DIV_RESET; div_cnt_q <= '0;
			ramp_q <= '0; trav_q <= '0; home_q <= '0; standt_q <= '0;
			step_lvl_q <= 1'b0; dir_q <= 1'b0;
		end else if (accept) begin
			homed_q <= homed_d; learned_q <= learned_d; mopen_q <= mopen_d;
			mclose_q <= mclose_d; run_q <= run_d; motor_q <= motor_d;
			cnt_en_q <= cnt_en_d; span_rd_q <= span_rd_d; prof_q <= prof_d;
			pass_q <= pass_d; wopen_q <= wopen_d; wclose_q <= wclose_d;
			stand_q <= stand_d; phase_q <= phase_d; fault_q <= fault_d;
			step_q <= step_d; open_span_q <= open_span_d; reopen_q <= reopen_d;
			cruise_q <= cruise_d; accel_q <= accel_d; speed_q <= speed_d;
			div_lim_q <= div_lim_d; div_cnt_q <= div_cnt_d; ramp_q <= ramp_d;
			trav_q <= trav_d; home_q <= home_d; standt_q <= standt_d;
			step_lvl_q <= step_lvl_d; dir_q <= dir_d;
		end
	end

	// output register
	tick_out_t res;
	always_comb begin
		res.step_pin = step_lvl_d;
		res.dir_pin = dir_d;
		res.hold_pin = |fault_d;
		res.motor_running = motor_d;
		if (fault_d[F_CLOSE_BIT])     res.error_code = ERR_CLOSE;
		else if (fault_d[F_OPEN_BIT]) res.error_code = ERR_OPEN;
		else if (fault_d[F_INIT_BIT]) res.error_code = ERR_INIT;
		else                          res.error_code = ERR_NONE;
		res.learned_span = 20'(open_span_d);
		res.homed = homed_d;
	end

	tick_out_t out_q;
	logic out_valid_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= res;
		end
	end
	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

@@ rtl/dsmc_cfg_regs.sv @@
// Configuration register file of the door controller.
// Depends on dsmc_pkg.
`timescale 1ns / 1ps
module dsmc_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [dsmc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [dsmc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output dsmc_pkg::cfg_t                      cfg
);
	import dsmc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.speed_min          <= 8'd50;
			cfg_q.speed_max          <= 8'd200;
			cfg_q.default_speed      <= 8'd100;
			cfg_q.ramp_up_interval   <= 8'd10;
			cfg_q.ramp_down_interval <= 8'd10;
			cfg_q.travel_timeout     <= 16'd10000;
			cfg_q.init_timeout       <= 16'd10000;
			cfg_q.standing_time      <= 16'd3000;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SPEED_MIN:     cfg_q.speed_min          <= cfg_data[7:0];
				REG_SPEED_MAX:     cfg_q.speed_max          <= cfg_data[7:0];
				REG_DEFAULT_SPEED: cfg_q.default_speed      <= cfg_data[7:0];
				REG_RAMP_UP:       cfg_q.ramp_up_interval   <= cfg_data[7:0];
				REG_RAMP_DOWN:     cfg_q.ramp_down_interval <= cfg_data[7:0];
				REG_TRAVEL_TO:     cfg_q.travel_timeout     <= cfg_data;
				REG_INIT_TO:       cfg_q.init_timeout       <= cfg_data;
				REG_STANDING_TIME: cfg_q.standing_time      <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/dsmc_checker.sv @@
// Port-level checker for the door controller, bound to the top level.
// Depends on dsmc_pkg.
`timescale 1ns / 1ps
module dsmc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input dsmc_pkg::tick_out_t out_data
);
	import dsmc_pkg::*;

	// every accepted tick produces a result next cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid) else $error("missing result");

	// a full, stalled output register blocks input
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready) else $error("overrun");

	// hold pin mirrors any latched error
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.hold_pin == (out_data.error_code != ERR_NONE)))
		else $error("hold mismatch");

	// a stalled result holds
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed");

endmodule

bind door_stepper_motion_controller dsmc_checker u_dsmc_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
